FILE: hdl/circular_fifo_with_search_macros.svh
// Assertion macros shared by the checker of the circular FIFO with search.
// No dependencies; included by files that hold concurrent assertions.
`ifndef CIRCULAR_FIFO_WITH_SEARCH_MACROS_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define CFS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define CFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/cfs_pkg.sv
// Shared types and helpers of the circular FIFO with search.
// No dependencies; imported by every module of the block.
package cfs_pkg;

	// Operation code carried from the front end to the execution unit.
	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_FIND,
		OP_NONE
	} op_t;

	// Execution unit states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_POP,
		BK_SCAN
	} back_state_t;

	// Header of one command: whether it is present and what it does.
	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_hdr_t;

	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_FIND = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	function automatic op_t mode_to_op(input logic [1:0] mode);
		op_t op;
		case (mode)
			MODE_PUSH: op = OP_PUSH;
			MODE_POP:  op = OP_POP;
			MODE_FIND: op = OP_FIND;
			default:   op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

FILE: hdl/cfs_front.sv
// Front end: start/busy handshake and classification of the mode code.
// Depends on cfs_pkg.
module cfs_front (
	input  logic              start,
	input  logic [1:0]        mode,
	input  logic              queue_ready,
	output logic              busy,
	output cfs_pkg::cmd_hdr_t hdr
);
	import cfs_pkg::*;

	assign busy      = !queue_ready;
	assign hdr.valid = start && queue_ready;
	assign hdr.op    = mode_to_op(mode);

endmodule

FILE: hdl/cfs_queue.sv
// Two-entry command queue between the front end and the execution unit.
// Depends on cfs_pkg.
module cfs_queue #(
	parameter int KEY_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfs_pkg::cmd_hdr_t    in_hdr,
	input  logic [KEY_WIDTH-1:0] in_first,
	input  logic [KEY_WIDTH-1:0] in_second,
	output logic                 in_ready,
	output cfs_pkg::cmd_hdr_t    out_hdr,
	output logic [KEY_WIDTH-1:0] out_first,
	output logic [KEY_WIDTH-1:0] out_second,
	input  logic                 out_take
);
	import cfs_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	op_t                  op_q     [QUEUE_DEPTH];
	logic [KEY_WIDTH-1:0] first_q  [QUEUE_DEPTH];
	logic [KEY_WIDTH-1:0] second_q [QUEUE_DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [NW-1:0]        fill_q;
	logic                 do_wr;
	logic                 do_rd;

	assign in_ready      = fill_q != NW'(QUEUE_DEPTH);
	assign do_wr         = in_hdr.valid && in_ready;
	assign do_rd         = out_take && (fill_q != '0);
	assign out_hdr.valid = fill_q != '0;
	assign out_hdr.op    = op_q[rd_ptr_q];
	assign out_first     = first_q[rd_ptr_q];
	assign out_second    = second_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			op_q[wr_ptr_q]     <= in_hdr.op;
			first_q[wr_ptr_q]  <= in_first;
			second_q[wr_ptr_q] <= in_second;
		end
	end

endmodule

FILE: hdl/cfs_back.sv
// Execution unit: entry memory, head/tail pointers and the sequential search.
// Depends on cfs_pkg.
module cfs_back #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 16,
	parameter int CW        = $clog2(CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfs_pkg::cmd_hdr_t    cmd_hdr,
	input  logic [KEY_WIDTH-1:0] cmd_first,
	input  logic [KEY_WIDTH-1:0] cmd_second,
	output logic                 cmd_take,
	output logic                 done,
	output logic [KEY_WIDTH-1:0] popped_first,
	output logic [KEY_WIDTH-1:0] popped_second,
	output logic                 pop_valid,
	output logic                 found,
	output logic [CW-1:0]        occupancy,
	output logic                 dropped
);
	import cfs_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [KEY_WIDTH-1:0] mem_first  [CAPACITY];
	logic [KEY_WIDTH-1:0] mem_second [CAPACITY];
	logic [KEY_WIDTH-1:0] rd_first_q;
	logic [KEY_WIDTH-1:0] rd_second_q;

	back_state_t          state_q, state_d;
	logic [AW-1:0]        head_q, head_d;
	logic [AW-1:0]        tail_q, tail_d;
	logic [CW-1:0]        count_q, count_d;
	logic [AW-1:0]        scan_ptr_q, scan_ptr_d;
	logic [CW-1:0]        left_q, left_d;
	logic                 pend_s1, pend_d;
	logic [KEY_WIDTH-1:0] key_first_q, key_first_d;
	logic [KEY_WIDTH-1:0] key_second_q, key_second_d;

	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic                 issue;
	logic                 hit;

	logic                 res_valid;
	logic [KEY_WIDTH-1:0] res_first;
	logic [KEY_WIDTH-1:0] res_second;
	logic                 res_pop_valid;
	logic                 res_found;
	logic                 res_dropped;

	logic                 done_q;
	logic [KEY_WIDTH-1:0] popped_first_q;
	logic [KEY_WIDTH-1:0] popped_second_q;
	logic                 pop_valid_q;
	logic                 found_q;
	logic [CW-1:0]        occupancy_q;
	logic                 dropped_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
		return (ptr == AW'(CAPACITY - 1)) ? '0 : ptr + 1'b1;
	endfunction

	// One entry is read each cycle during a search; the compare uses the
	// data read in the previous cycle.
	assign issue = left_q != '0;
	assign hit   = pend_s1 && (rd_first_q == key_first_q) && (rd_second_q == key_second_q);

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		tail_d        = tail_q;
		count_d       = count_q;
		scan_ptr_d    = scan_ptr_q;
		left_d        = left_q;
		pend_d        = 1'b0;
		key_first_d   = key_first_q;
		key_second_d  = key_second_q;
		cmd_take      = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_raddr     = head_q;
		res_valid     = 1'b0;
		res_first     = '0;
		res_second    = '0;
		res_pop_valid = 1'b0;
		res_found     = 1'b0;
		res_dropped   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_hdr.valid) begin
					cmd_take = 1'b1;
					case (cmd_hdr.op)
						OP_PUSH: begin
							res_valid = 1'b1;
							if (count_q == CW'(CAPACITY)) begin
								res_dropped = 1'b1;
							end else begin
								mem_we  = 1'b1;
								tail_d  = wrap_inc(tail_q);
								count_d = count_q + 1'b1;
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								res_valid = 1'b1;
							end else begin
								mem_re  = 1'b1;
								state_d = BK_POP;
							end
						end
						OP_FIND: begin
							if (count_q == '0) begin
								res_valid = 1'b1;
							end else begin
								key_first_d  = cmd_first;
								key_second_d = cmd_second;
								scan_ptr_d   = head_q;
								left_d       = count_q;
								state_d      = BK_SCAN;
							end
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			BK_POP: begin
				res_valid     = 1'b1;
				res_pop_valid = 1'b1;
				res_first     = rd_first_q;
				res_second    = rd_second_q;
				head_d        = wrap_inc(head_q);
				count_d       = count_q - 1'b1;
				state_d       = BK_IDLE;
			end
			BK_SCAN: begin
				mem_raddr = scan_ptr_q;
				if (hit) begin
					res_valid = 1'b1;
					res_found = 1'b1;
					left_d    = '0;
					state_d   = BK_IDLE;
				end else if (!issue && !pend_s1) begin
					res_valid = 1'b1;
					state_d   = BK_IDLE;
				end else if (issue) begin
					mem_re     = 1'b1;
					pend_d     = 1'b1;
					scan_ptr_d = wrap_inc(scan_ptr_q);
					left_d     = left_q - 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			scan_ptr_q <= '0;
			left_q     <= '0;
			pend_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			scan_ptr_q <= scan_ptr_d;
			left_q     <= left_d;
			pend_s1    <= pend_d;
			done_q     <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		key_first_q  <= key_first_d;
		key_second_q <= key_second_d;
		if (res_valid) begin
			popped_first_q  <= res_first;
			popped_second_q <= res_second;
			pop_valid_q     <= res_pop_valid;
			found_q         <= res_found;
			occupancy_q     <= count_d;
			dropped_q       <= res_dropped;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_first[tail_q]  <= cmd_first;
			mem_second[tail_q] <= cmd_second;
		end
		if (mem_re) begin
			rd_first_q  <= mem_first[mem_raddr];
			rd_second_q <= mem_second[mem_raddr];
		end
	end

	assign done          = done_q;
	assign popped_first  = popped_first_q;
	assign popped_second = popped_second_q;
	assign pop_valid     = pop_valid_q;
	assign found         = found_q;
	assign occupancy     = occupancy_q;
	assign dropped       = dropped_q;

endmodule

FILE: hdl/circular_fifo_with_search.sv
// Circular FIFO of key pairs with push, pop and content search.
// Depends on cfs_pkg, cfs_front, cfs_queue and cfs_back.
//
// A transaction is taken at a rising edge with start high and busy low;
// its result appears on the result ports for one cycle with done high and
// must be captured then, since the receiver cannot hold results off. A
// two-entry command queue sits behind the input, so busy rises only when
// two transactions wait. The execution unit works on one transaction at a
// time: pop does one registered memory read, and find reads the stored
// entries one per cycle from head toward tail and stops at the first match,
// so a find that misses reads every stored entry. A pop or find on an empty
// FIFO finishes without a memory read. Results come out in transaction
// order, and occupancy always reports the entry count after the operation.
module circular_fifo_with_search #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       mode,
	input  logic [KEY_WIDTH-1:0]             first_key,
	input  logic [KEY_WIDTH-1:0]             second_key,
	output logic                             done,
	output logic [KEY_WIDTH-1:0]             popped_first,
	output logic [KEY_WIDTH-1:0]             popped_second,
	output logic                             pop_valid,
	output logic                             found,
	output logic [$clog2(CAPACITY + 1)-1:0]  occupancy,
	output logic                             dropped
);
	import cfs_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	cmd_hdr_t             front_hdr;
	cmd_hdr_t             queue_hdr;
	logic                 queue_ready;
	logic [KEY_WIDTH-1:0] queue_first;
	logic [KEY_WIDTH-1:0] queue_second;
	logic                 queue_take;

	cfs_front u_front (
		.start       (start),
		.mode        (mode),
		.queue_ready (queue_ready),
		.busy        (busy),
		.hdr         (front_hdr)
	);

	cfs_queue #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_hdr     (front_hdr),
		.in_first   (first_key),
		.in_second  (second_key),
		.in_ready   (queue_ready),
		.out_hdr    (queue_hdr),
		.out_first  (queue_first),
		.out_second (queue_second),
		.out_take   (queue_take)
	);

	cfs_back #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH),
		.CW        (CW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_hdr       (queue_hdr),
		.cmd_first     (queue_first),
		.cmd_second    (queue_second),
		.cmd_take      (queue_take),
		.done          (done),
		.popped_first  (popped_first),
		.popped_second (popped_second),
		.pop_valid     (pop_valid),
		.found         (found),
		.occupancy     (occupancy),
		.dropped       (dropped)
	);

endmodule

FILE: hdl/cfs_checker.sv
// Port-level checker of the circular FIFO with search, bound to the top level.
// Depends on circular_fifo_with_search_macros.svh and circular_fifo_with_search.
`include "circular_fifo_with_search_macros.svh"

module cfs_checker #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 16,
	parameter int CW        = $clog2(CAPACITY + 1)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 done,
	input logic [KEY_WIDTH-1:0] popped_first,
	input logic [KEY_WIDTH-1:0] popped_second,
	input logic                 pop_valid,
	input logic                 found,
	input logic [CW-1:0]        occupancy,
	input logic                 dropped
);

	// A result reports at most one kind of outcome.
	`CFS_ASSERT(a_one_outcome, clk, arst_n, done |-> $onehot0({pop_valid, found, dropped}), "more than one outcome flag in a result")

	// A refused push can only happen with every slot taken.
	`CFS_ASSERT(a_drop_when_full, clk, arst_n, (done && dropped) |-> (occupancy == CW'(CAPACITY)), "push refused below capacity")

	// Popped fields are zero unless a pop returned an entry.
	`CFS_ASSERT(a_pop_zero, clk, arst_n, (done && !pop_valid) |-> (popped_first == '0 && popped_second == '0), "popped fields not zero")

	// Occupancy never exceeds the capacity.
	`CFS_ASSERT(a_occ_range, clk, arst_n, done |-> (occupancy <= CW'(CAPACITY)), "occupancy above capacity")

	// No result strobe while reset is asserted.
	`CFS_ASSERT_ALWAYS(a_no_done_in_reset, clk, !arst_n |-> !done, "result strobe during reset")

endmodule

bind circular_fifo_with_search cfs_checker #(
	.CAPACITY  (CAPACITY),
	.KEY_WIDTH (KEY_WIDTH),
	.CW        (CW)
) u_cfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.done          (done),
	.popped_first  (popped_first),
	.popped_second (popped_second),
	.pop_valid     (pop_valid),
	.found         (found),
	.occupancy     (occupancy),
	.dropped       (dropped)
);

FILE: tb/sv/cfs_result_checker.sv
// Result checker for the circular FIFO with search: predicts every result and compares it.
// Depends on cfs_pkg for the mode codes; instantiated by tb_circular_fifo_with_search.
module cfs_result_checker #(
	parameter int KEY_W    = 16,
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [1:0]       mode,
	input  logic [KEY_W-1:0] first_key,
	input  logic [KEY_W-1:0] second_key,
	input  logic             done,
	input  logic [KEY_W-1:0] popped_first,
	input  logic [KEY_W-1:0] popped_second,
	input  logic             pop_valid,
	input  logic             found,
	input  logic [CW-1:0]    occupancy,
	input  logic             dropped,
	output int               fail_count,
	output int               results_pending,
	output int               results_checked,
	output int               finds_hit,
	output int               pushes_dropped,
	output int               pops_empty
);
	import cfs_pkg::*;

	typedef struct packed {
		logic [KEY_W-1:0] pop_first;
		logic [KEY_W-1:0] pop_second;
		logic             pop_ok;
		logic             hit;
		logic [CW-1:0]    occ;
		logic             drop;
	} fifo_result_t;

	// Shadow copy of the ring buffer.
	logic [KEY_W-1:0] ring_first [CAPACITY];
	logic [KEY_W-1:0] ring_second [CAPACITY];
	int unsigned      ring_head;
	int unsigned      ring_tail;
	int unsigned      ring_count;

	fifo_result_t expected_results[$];
	fifo_result_t want;

	function automatic int unsigned next_slot(input int unsigned slot);
		return (slot == CAPACITY - 1) ? 0 : slot + 1;
	endfunction

	// Applies one transaction to the shadow ring and returns the result it must produce.
	function automatic fifo_result_t apply_fifo_op(input logic [1:0] op_mode,
			input logic [KEY_W-1:0] key_a, input logic [KEY_W-1:0] key_b);
		fifo_result_t r;
		int unsigned slot;
		r = '0;
		case (op_mode)
			MODE_PUSH: begin
				if (ring_count >= CAPACITY) begin
					r.drop = 1'b1;
				end else begin
					ring_first[ring_tail] = key_a;
					ring_second[ring_tail] = key_b;
					ring_tail = next_slot(ring_tail);
					ring_count++;
				end
			end
			MODE_POP: begin
				if (ring_count != 0) begin
					r.pop_first = ring_first[ring_head];
					r.pop_second = ring_second[ring_head];
					r.pop_ok = 1'b1;
					ring_head = next_slot(ring_head);
					ring_count--;
				end
			end
			MODE_FIND: begin
				slot = ring_head;
				for (int n = 0; n < ring_count; n++) begin
					if (ring_first[slot] == key_a && ring_second[slot] == key_b) begin
						r.hit = 1'b1;
						break;
					end
					slot = next_slot(slot);
				end
			end
			default: ;
		endcase
		r.occ = ring_count[CW-1:0];
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_head = 0;
			ring_tail = 0;
			ring_count = 0;
			expected_results.delete();
			fail_count = 0;
			results_pending = 0;
			results_checked = 0;
			finds_hit = 0;
			pushes_dropped = 0;
			pops_empty = 0;
		end else begin
			// The new transaction goes to the back, so the front is still the oldest one.
			if (start && !busy) begin
				want = apply_fifo_op(mode, first_key, second_key);
				expected_results.push_back(want);
				if (want.hit) finds_hit++;
				if (want.drop) pushes_dropped++;
				if (mode == MODE_POP && !want.pop_ok) pops_empty++;
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction waiting for it");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("popped_first", want.pop_first, popped_first);
					check_field("popped_second", want.pop_second, popped_second);
					check_field("pop_valid", want.pop_ok, pop_valid);
					check_field("found", want.hit, found);
					check_field("occupancy", want.occ, occupancy);
					check_field("dropped", want.drop, dropped);
					results_checked++;
				end
			end
			results_pending = expected_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_circular_fifo_with_search.sv
// Testbench top for the circular FIFO with search: drives transactions and gives the verdict.
// Depends on cfs_pkg, circular_fifo_with_search and cfs_result_checker.
module tb_circular_fifo_with_search;
	import cfs_pkg::*;

	localparam int KEY_W          = 16;
	localparam int CAPACITY       = 16;
	localparam int CW             = 5;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 50;
	localparam int PHASE_ITEMS    = 445;
	localparam logic [1:0] MODE_NONE = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       mode;
	logic [KEY_W-1:0] first_key;
	logic [KEY_W-1:0] second_key;
	logic             done;
	logic [KEY_W-1:0] popped_first;
	logic [KEY_W-1:0] popped_second;
	logic             pop_valid;
	logic             found;
	logic [CW-1:0]    occupancy;
	logic             dropped;

	int fail_count;
	int results_pending;
	int results_checked;
	int finds_hit;
	int pushes_dropped;
	int pops_empty;

	logic took;
	int   idle_cycles;
	int   sent_by_mode [4];

	logic [KEY_W-1:0] pool_first [8];
	logic [KEY_W-1:0] pool_second [8];

	circular_fifo_with_search #(
		.CAPACITY(CAPACITY),
		.KEY_WIDTH(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.first_key(first_key),
		.second_key(second_key),
		.done(done),
		.popped_first(popped_first),
		.popped_second(popped_second),
		.pop_valid(pop_valid),
		.found(found),
		.occupancy(occupancy),
		.dropped(dropped)
	);

	cfs_result_checker #(
		.KEY_W(KEY_W),
		.CAPACITY(CAPACITY),
		.CW(CW)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.first_key(first_key),
		.second_key(second_key),
		.done(done),
		.popped_first(popped_first),
		.popped_second(popped_second),
		.pop_valid(pop_valid),
		.found(found),
		.occupancy(occupancy),
		.dropped(dropped),
		.fail_count(fail_count),
		.results_pending(results_pending),
		.results_checked(results_checked),
		.finds_hit(finds_hit),
		.pushes_dropped(pushes_dropped),
		.pops_empty(pops_empty)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The flag is sampled at the rising edge and read by the driver at the next falling edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** circular_fifo_with_search: FAILED **");
				$finish;
			end
		end
	end

	// Holds start high with the given fields until the block takes the transaction.
	task automatic issue(input logic [1:0] m, input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b);
		mode = m;
		first_key = a;
		second_key = b;
		start = 1'b1;
		do @(negedge clk); while (!took);
		sent_by_mode[m]++;
	endtask

	task automatic pause(input int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain;
		start = 1'b0;
		while (results_pending != 0) @(negedge clk);
	endtask

	// Keys mostly come from a small pool so that finds hit stored entries.
	task automatic pick_keys(output logic [KEY_W-1:0] a, output logic [KEY_W-1:0] b);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			r = $urandom_range(0, 7);
			a = pool_first[r];
			b = pool_second[r];
		end else if (r < 70) begin
			a = pool_first[$urandom_range(0, 7)];
			b = pool_second[$urandom_range(0, 7)];
		end else begin
			a = KEY_W'($urandom());
			b = KEY_W'($urandom());
		end
	endtask

	initial begin
		int idle_pct [3];
		int push_pct;
		int r;
		logic [1:0] m;
		logic [KEY_W-1:0] a;
		logic [KEY_W-1:0] b;

		idle_pct = '{0, 68, 33};
		for (int i = 0; i < 4; i++) sent_by_mode[i] = 0;
		pool_first[0] = '0;
		pool_second[0] = '0;
		pool_first[1] = '1;
		pool_second[1] = '1;
		for (int i = 2; i < 8; i++) begin
			pool_first[i] = KEY_W'($urandom());
			pool_second[i] = KEY_W'($urandom());
		end

		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_PUSH;
		first_key = '0;
		second_key = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Operations on an empty queue, then the key extremes.
		issue(MODE_FIND, '0, '0);
		issue(MODE_POP, '1, '1);
		issue(MODE_NONE, '0, '0);
		issue(MODE_PUSH, '0, '0);
		issue(MODE_PUSH, '1, '1);
		issue(MODE_PUSH, '1, '0);
		issue(MODE_FIND, '1, '1);
		issue(MODE_FIND, '1, 16'h0001);
		issue(MODE_POP, '0, '0);
		// Fill to capacity, overflow once, and search for the newest entry.
		for (int i = 0; i < CAPACITY - 2; i++) begin
			issue(MODE_PUSH, KEY_W'(i * 16'h1111), ~KEY_W'(i * 16'h1111));
		end
		issue(MODE_PUSH, 16'h5A5A, 16'hA5A5);
		issue(MODE_FIND, KEY_W'(13 * 16'h1111), ~KEY_W'(13 * 16'h1111));
		issue(MODE_NONE, '1, '1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			push_pct = 50;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// The push share drifts so the queue swings between empty and full.
				if (i % 40 == 0) push_pct = $urandom_range(15, 70);
				r = $urandom_range(0, 99);
				if (r < push_pct) m = MODE_PUSH;
				else if (r < push_pct + 25) m = MODE_FIND;
				else if (r < push_pct + 29) m = MODE_NONE;
				else m = MODE_POP;
				pick_keys(a, b);
				issue(m, a, b);
				if ($urandom_range(0, 99) < idle_pct[phase]) begin
					if ($urandom_range(0, 9) == 0) pause($urandom_range(10, 24));
					else pause($urandom_range(1, 4));
				end
				if (i % 150 == 149) drain();
			end
			drain();
		end

		start = 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d transactions: %0d push, %0d pop, %0d find, %0d unused mode.",
			sent_by_mode[0] + sent_by_mode[1] + sent_by_mode[2] + sent_by_mode[3],
			sent_by_mode[0], sent_by_mode[1], sent_by_mode[2], sent_by_mode[3]);
		$display("Checked %0d results: %0d find hits, %0d drops on full, %0d pops on empty.",
			results_checked, finds_hit, pushes_dropped, pops_empty);
		if (fail_count == 0) begin
			$display("** circular_fifo_with_search: PASSED **");
		end else begin
			$display("** circular_fifo_with_search: FAILED **");
		end
		$finish;
	end

endmodule
